/* rtl/edit_lock_with_wait_queue_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the edit lock with wait queue
// Shared shorthands for concurrent assertions with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef EDIT_LOCK_WITH_WAIT_QUEUE_ASSERT_SVH
`define EDIT_LOCK_WITH_WAIT_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ELWQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ELWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/elwq_pkg.sv */
// ----------------------------------------------------------------------------
// elwq_pkg
// Types, widths and codes shared by the edit lock with wait queue.
// ----------------------------------------------------------------------------
package elwq_pkg;

  localparam int ID_W            = 8;
  localparam int VER_W           = 16;
  localparam int ST_W            = 2;
  localparam int WAIT_W          = 5;
  localparam int QUEUE_DEPTH_DEF = 16;

  // Operation codes on the input channel.
  localparam logic OP_REQ = 1'b0;
  localparam logic OP_REL = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_RELEASED = 2'd3
  } elwq_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic pop_rd;
    logic commit;
  } elwq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_rel;
    logic busy;
    logic holder_eq;
    logic q_empty;
    logic q_full;
    logic scan_hit;
    logic scan_end;
  } elwq_sts_t;

endpackage

/* rtl/elwq_ifs.sv */
// ----------------------------------------------------------------------------
// elwq channel interfaces
// Valid/ready channels for operations in and lock results out.
// ----------------------------------------------------------------------------
interface elwq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [elwq_pkg::ID_W-1:0] client_id;

  modport source (output valid, output op, output client_id, input ready);
  modport sink (input valid, input op, input client_id, output ready);
endinterface

interface elwq_out_if;
  logic                        valid;
  logic                        ready;
  logic [elwq_pkg::ST_W-1:0]   status;
  logic                        was_added;
  logic                        handoff_valid;
  logic [elwq_pkg::ID_W-1:0]   handoff_id;
  logic [elwq_pkg::VER_W-1:0]  version;
  logic                        busy_res;
  logic [elwq_pkg::WAIT_W-1:0] waiting;

  modport source (output valid, output status, output was_added, output handoff_valid,
                  output handoff_id, output version, output busy_res, output waiting,
                  input ready);
  modport sink (input valid, input status, input was_added, input handoff_valid,
                input handoff_id, input version, input busy_res, input waiting,
                output ready);
endinterface

/* rtl/elwq_ram.sv */
// ----------------------------------------------------------------------------
// elwq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module elwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/elwq_dp.sv */
// ----------------------------------------------------------------------------
// elwq_dp
// Lock state, circular wait queue, membership scan and result register.
// ----------------------------------------------------------------------------
module elwq_dp #(
  parameter int QUEUE_DEPTH = elwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_op,
  input  logic [elwq_pkg::ID_W-1:0]     in_client_id,
  input  elwq_pkg::elwq_cmd_t           cmd,
  output elwq_pkg::elwq_sts_t           sts,
  output logic [elwq_pkg::ST_W-1:0]     res_status,
  output logic                          res_was_added,
  output logic                          res_handoff_valid,
  output logic [elwq_pkg::ID_W-1:0]     res_handoff_id,
  output logic [elwq_pkg::VER_W-1:0]    res_version,
  output logic                          res_busy,
  output logic [elwq_pkg::WAIT_W-1:0]   res_waiting
);
  import elwq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic             op_r;
  logic [ID_W-1:0]  id_r;
  logic             busy_r, busy_nxt;
  logic [ID_W-1:0]  holder_r, holder_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [VER_W-1:0] ver_r, ver_nxt;
  logic [CNT_W-1:0] scan_i_r;
  logic [PTR_W-1:0] rp_r;
  logic             cmp_v_r;
  logic             hit_r;

  logic             issue;
  logic             ram_re;
  logic [PTR_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;
  logic             q_empty, q_full, scan_hit;

  elwq_status_t     st;
  logic             add, hv;
  logic [ID_W-1:0]  hid;
  logic [VER_W-1:0] ver_out;

  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign issue    = cmd.scan_step && (scan_i_r != count_r);
  assign scan_hit = cmp_v_r && (ram_rdata == id_r);

  assign ram_re    = issue || cmd.pop_rd;
  assign ram_raddr = cmd.pop_rd ? head_r : rp_r;

  assign sts.op_rel    = (op_r == OP_REL);
  assign sts.busy      = busy_r;
  assign sts.holder_eq = (holder_r == id_r);
  assign sts.q_empty   = q_empty;
  assign sts.q_full    = q_full;
  assign sts.scan_hit  = scan_hit;
  assign sts.scan_end  = (scan_i_r == count_r);

  elwq_ram #(
    .WIDTH (ID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && add),
    .waddr (tail_r),
    .wdata (id_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Outcome of the operation, applied when the controller commits.
  always_comb begin
    busy_nxt   = busy_r;
    holder_nxt = holder_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    ver_nxt    = ver_r;
    st         = ST_QUEUED;
    add        = 1'b0;
    hv         = 1'b0;
    hid        = '0;
    ver_out    = '0;
    if (op_r == OP_REQ) begin
      if (!busy_r) begin
        busy_nxt   = 1'b1;
        holder_nxt = id_r;
        st         = ST_GRANTED;
      end else if (!hit_r && !q_full) begin
        add       = 1'b1;
        count_nxt = count_r + 1'b1;
        tail_nxt  = ptr_inc(tail_r);
      end
    end else if (!busy_r || (holder_r != id_r)) begin
      st = ST_REJECTED;
    end else begin
      st      = ST_RELEASED;
      ver_out = ver_r;
      ver_nxt = ver_r + 1'b1;
      if (!q_empty) begin
        holder_nxt = ram_rdata;
        hv         = 1'b1;
        hid        = ram_rdata;
        count_nxt  = count_r - 1'b1;
        head_nxt   = ptr_inc(head_r);
      end else begin
        busy_nxt   = 1'b0;
        holder_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      holder_r <= '0;
      count_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      ver_r    <= VER_W'(1);
      scan_i_r <= '0;
      rp_r     <= '0;
      cmp_v_r  <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        hit_r <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_i_r <= '0;
        rp_r     <= head_r;
        cmp_v_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_v_r <= issue;
        if (issue) begin
          scan_i_r <= scan_i_r + 1'b1;
          rp_r     <= ptr_inc(rp_r);
        end
        if (scan_hit) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        busy_r   <= busy_nxt;
        holder_r <= holder_nxt;
        count_r  <= count_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        ver_r    <= ver_nxt;
      end
    end
  end

  // Operation latch and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_op;
      id_r <= in_client_id;
    end
    if (cmd.commit) begin
      res_status        <= st;
      res_was_added     <= add;
      res_handoff_valid <= hv;
      res_handoff_id    <= hid;
      res_version       <= ver_out;
      res_busy          <= busy_nxt;
      res_waiting       <= WAIT_W'(count_nxt);
    end
  end

endmodule

/* rtl/elwq_ctrl.sv */
// ----------------------------------------------------------------------------
// elwq_ctrl
// Sequencer for one operation at a time and the result valid flag.
// ----------------------------------------------------------------------------
module elwq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output elwq_pkg::elwq_cmd_t cmd,
  input  elwq_pkg::elwq_sts_t sts
);
  import elwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FIN   = 4'b1000
  } elwq_state_t;

  elwq_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_FIN;
        if (!sts.op_rel) begin
          if (sts.busy && !sts.q_empty && !sts.q_full) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.busy && sts.holder_eq && !sts.q_empty) begin
          cmd.pop_rd = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/edit_lock_with_wait_queue.sv */
// ----------------------------------------------------------------------------
// edit_lock_with_wait_queue
// Single-holder edit lock with a first-in first-out queue of waiting clients.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                              Handshake
//  in_if    in   op, client_id                                        valid/ready
//  out_if   out  status, was_added, handoff_valid, handoff_id,        valid/ready
//                version, busy_res, waiting
//
//  A transaction steps through accept, check and commit. A request while the
//  lock is held and the queue is neither empty nor full also scans the queue
//  through the single read port of the queue RAM, one waiter a cycle, and
//  stops early on a match. Reset is synchronous and needs no clearing pass.
//  A stalled result sits in the output register while the next transaction
//  is accepted; that transaction waits at commit until the register frees.
// ----------------------------------------------------------------------------
module edit_lock_with_wait_queue #(
  parameter int QUEUE_DEPTH = elwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  elwq_in_if.sink    in_if,
  elwq_out_if.source out_if
);
  import elwq_pkg::*;

  // Commands and status between the sequencer and the datapath.
  elwq_cmd_t cmd;
  elwq_sts_t sts;

  // The controller owns both handshakes and the order of the work steps.
  elwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the lock state, the queue RAM with its head and tail
  // pointers, the version counter and the result register.
  elwq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_if.op),
    .in_client_id      (in_if.client_id),
    .cmd               (cmd),
    .sts               (sts),
    .res_status        (out_if.status),
    .res_was_added     (out_if.was_added),
    .res_handoff_valid (out_if.handoff_valid),
    .res_handoff_id    (out_if.handoff_id),
    .res_version       (out_if.version),
    .res_busy          (out_if.busy_res),
    .res_waiting       (out_if.waiting)
  );

endmodule

/* rtl/elwq_chk.sv */
// ----------------------------------------------------------------------------
// elwq_chk
// Port-level assertions for the edit lock with wait queue, bound to the top.
// ----------------------------------------------------------------------------
`include "edit_lock_with_wait_queue_assert.svh"

module elwq_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [elwq_pkg::ST_W-1:0]     out_status,
  input logic                          out_was_added,
  input logic                          out_handoff_valid,
  input logic [elwq_pkg::ID_W-1:0]     out_handoff_id,
  input logic [elwq_pkg::VER_W-1:0]    out_version,
  input logic                          out_busy_res
);
  import elwq_pkg::*;

  // One transaction at a time: the input closes right after an acceptance.
  `ELWQ_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

  // A stalled result holds.
  `ELWQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_version) && $stable(out_handoff_id), "stalled result changed")

  // A handoff only happens on a release and leaves the lock held.
  `ELWQ_ASSERT_NOW(a_handoff, clk, rst_n, out_valid && out_handoff_valid, (out_status == ST_RELEASED) && out_busy_res, "handoff without release")

  // A grant leaves the lock held and carries no version, append or handoff.
  `ELWQ_ASSERT_NOW(a_grant, clk, rst_n, out_valid && (out_status == ST_GRANTED), out_busy_res && !out_was_added && !out_handoff_valid && (out_version == '0), "inconsistent grant")

endmodule

bind edit_lock_with_wait_queue elwq_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_status        (out_if.status),
  .out_was_added     (out_if.was_added),
  .out_handoff_valid (out_if.handoff_valid),
  .out_handoff_id    (out_if.handoff_id),
  .out_version       (out_if.version),
  .out_busy_res      (out_if.busy_res)
);

/* sim/lock_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock result checker
// Watches both channels of the edit lock, keeps its own lock, queue and
// version state, and compares every result with the one it predicts.
// ----------------------------------------------------------------------------
module lock_result_checker #(
  parameter int QUEUE_DEPTH = elwq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  elwq_in_if   in_if,
  elwq_out_if  out_if,
  output int   fail_count,
  output int   outstanding
);
  import elwq_pkg::*;

  typedef struct packed {
    elwq_status_t       status;
    logic               was_added;
    logic               handoff_valid;
    logic [ID_W-1:0]    handoff_id;
    logic [VER_W-1:0]   version;
    logic               busy_res;
    logic [WAIT_W-1:0]  waiting;
  } lock_result_t;

  bit                lock_held;
  logic [ID_W-1:0]   owner;
  logic [ID_W-1:0]   waiters[$];
  logic [VER_W-1:0]  next_ver;
  lock_result_t      due_results[$];

  // Applies one operation to the shadow lock and returns the answer it gives.
  function automatic lock_result_t predict_lock(input logic op, input logic [ID_W-1:0] id);
    lock_result_t r;
    bit           already_waiting;
    r = '0;
    already_waiting = 1'b0;
    if (op == OP_REQ) begin
      if (!lock_held) begin
        lock_held = 1'b1;
        owner     = id;
        r.status  = ST_GRANTED;
      end else begin
        r.status = ST_QUEUED;
        foreach (waiters[i]) if (waiters[i] == id) already_waiting = 1'b1;
        if (!already_waiting && waiters.size() < QUEUE_DEPTH) begin
          waiters.push_back(id);
          r.was_added = 1'b1;
        end
      end
    end else if (!lock_held || owner != id) begin
      r.status = ST_REJECTED;
    end else begin
      r.status  = ST_RELEASED;
      r.version = next_ver;
      next_ver  = next_ver + 1'b1;
      if (waiters.size() != 0) begin
        owner           = waiters.pop_front();
        r.handoff_valid = 1'b1;
        r.handoff_id    = owner;
      end else begin
        lock_held = 1'b0;
        owner     = '0;
      end
    end
    r.busy_res = lock_held;
    r.waiting  = WAIT_W'(waiters.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lock_result_t want;
    if (!rst_n) begin
      lock_held = 1'b0;
      owner     = '0;
      next_ver  = 16'd1;
      waiters.delete();
      due_results.delete();
    end else begin
      // A result can never belong to an operation accepted at the same edge,
      // so results are matched before the new operation is predicted.
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $error("result with status %0d arrived with nothing outstanding", out_if.status);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("was_added", want.was_added, out_if.was_added);
          check_field("handoff_valid", want.handoff_valid, out_if.handoff_valid);
          check_field("handoff_id", want.handoff_id, out_if.handoff_id);
          check_field("version", want.version, out_if.version);
          check_field("busy_res", want.busy_res, out_if.busy_res);
          check_field("waiting", want.waiting, out_if.waiting);
        end
      end
      if (in_if.valid && in_if.ready)
        due_results.push_back(predict_lock(in_if.op, in_if.client_id));
    end
    outstanding <= due_results.size();
  end

endmodule

/* sim/edit_lock_with_wait_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit lock with wait queue testbench
// Drives lock requests and releases through the block, with random gaps on
// the sender and random stalls on the receiver, and lets a checker beside
// the block predict and compare every result.
// ----------------------------------------------------------------------------
module edit_lock_with_wait_queue_test;
  import elwq_pkg::*;

  localparam int CYCLE_LIMIT = 250_000;
  // Back-to-back grant/release pairs with no idling on either side.
  localparam int BURST_PAIRS = 16;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 176;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  elwq_in_if  in_if();
  elwq_out_if out_if();

  int fail_count;
  int outstanding;
  int cycle_count;
  int sent_total;
  int overflow_tries;

  // When set, the sender or the receiver runs without any idle cycles.
  bit tx_calm;
  bit rx_calm;
  int rx_hold;

  // Steering view of the lock: entry 0 is the holder, the rest are the
  // waiters in order. Stimulus uses it to aim releases at the real holder.
  logic [ID_W-1:0] lock_line[$];

  // Per-phase shape of the random traffic: how many distinct clients are in
  // play and how often an item is a release.
  int pool_size[PHASES] = '{4, 20, 40, 12, 24, 200};
  int rel_pct[PHASES]   = '{40, 25, 30, 60, 35, 50};

  edit_lock_with_wait_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  lock_result_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
  ) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .out_if     (out_if),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver. After each accepted result it draws a stall length and holds
  // ready low while it counts that down; in calm stretches it never stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      rx_hold = rx_calm ? 0 : $urandom_range(0, 9);
      out_if.ready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_if.ready <= (rx_hold == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Sends one operation. The task is entered at a rising edge and returns at
  // the edge where the transaction was accepted, with valid still high, so a
  // following operation with no gap keeps valid up without a glitch. Any
  // caller that waits between operations must lower valid first.
  task automatic issue(input logic op, input logic [ID_W-1:0] id);
    int gap;
    bit already_waiting;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    already_waiting = 1'b0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.client_id <= id;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_total++;

    // Keep the steering view in step with what the lock now looks like.
    if (op == OP_REQ) begin
      if (lock_line.size() == 0) begin
        lock_line.push_back(id);
      end else begin
        for (int k = 1; k < lock_line.size(); k++)
          if (lock_line[k] == id) already_waiting = 1'b1;
        if (!already_waiting) begin
          if (lock_line.size() <= QUEUE_DEPTH_DEF) lock_line.push_back(id);
          else overflow_tries++;
        end
      end
    end else if (lock_line.size() != 0 && lock_line[0] == id) begin
      void'(lock_line.pop_front());
    end
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [ID_W-1:0] pool[$];
    logic            op;
    logic [ID_W-1:0] id;

    // Every input of the block is at a known value from time zero.
    in_if.valid     = 1'b0;
    in_if.op        = OP_REQ;
    in_if.client_id = '0;
    out_if.ready    = 1'b0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, with random idling on both sides.
    issue(OP_REL, 8'h00);  // release while nobody holds the lock is rejected
    issue(OP_REQ, 8'h00);  // free lock is granted at once
    issue(OP_REQ, 8'hFF);  // another client is queued and added
    issue(OP_REQ, 8'hFF);  // the same client again is queued but not added
    issue(OP_REQ, 8'h00);  // the holder itself asks again and joins the queue
    issue(OP_REL, 8'hFF);  // a waiter cannot release
    issue(OP_REL, 8'h00);  // holder releases, lock passes to the head waiter
    issue(OP_REL, 8'hFF);  // lock goes back to the client that held it before
    // Fill the queue to its depth with ids that toggle every bit, including
    // the holder's own id, then try once more against the full queue.
    for (int k = 0; k < QUEUE_DEPTH_DEF; k++) issue(OP_REQ, 8'(k * 17));
    issue(OP_REQ, 8'h5A);

    // Drain the lock through its whole chain of handoffs until it is free.
    while (lock_line.size() != 0) issue(OP_REL, lock_line[0]);

    // A back-to-back run of grant and release pairs with no idling on
    // either side, each pair from a random client.
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    for (int k = 0; k < BURST_PAIRS; k++) begin
      id = ID_W'($urandom_range(0, 255));
      issue(OP_REQ, id);
      issue(OP_REL, id);
    end

    // Random phases. Most releases are aimed at the current holder so that
    // the lock keeps changing hands and the queue fills and drains; the rest
    // come from other clients and are rejected.
    for (int ph = 0; ph < PHASES; ph++) begin
      tx_calm = (ph == 2);
      rx_calm = (ph == 2) || (ph == 4);
      pool.delete();
      repeat (pool_size[ph]) pool.push_back(ID_W'($urandom_range(0, 255)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < rel_pct[ph]) begin
          op = OP_REL;
          if (lock_line.size() != 0 && $urandom_range(0, 99) < 80) id = lock_line[0];
          else id = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          op = OP_REQ;
          if ($urandom_range(0, 99) < 85) id = pool[$urandom_range(0, pool.size() - 1)];
          else id = ID_W'($urandom_range(0, 255));
        end
        issue(op, id);
      end
      // Let the block run completely dry between some phases.
      if (ph == 1 || ph == 3) settle();
    end

    settle();
    // Keep the clock running to catch any result the block should not produce.
    repeat (40) @(posedge clk);

    $display("Sent %0d lock operations, %0d of them in a back-to-back grant and release run;",
             sent_total, 2 * BURST_PAIRS);
    $display("requests met a full queue %0d times.", overflow_tries);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
